@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/ducs_pkg.sv @@
// shared types, constants and functions of the debounced counter display core
// no dependencies
package ducs_pkg;

  localparam int BTN_COUNT = 3;
  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT = 1;
  localparam int BTN_MIDDLE = 2;

  localparam logic [6:0] COUNT_TOP = 7'd99;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;
  localparam logic [7:0] MUX_PERIOD_RESET = 8'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 3;
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_MUX_PERIOD = 1'b1;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] mux_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic right_active;
    logic [BTN_COUNT-1:0] act;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [6:0] digit_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0: p = 7'h3F;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      default: p = 7'h6F;
    endcase
    return p;
  endfunction

  // divide by ten via reciprocal, exact for values below 128
  function automatic logic [3:0] tens_of(input logic [6:0] c);
    logic [14:0] p;
    p = 15'(c) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] c);
    logic [6:0] t10;
    logic [6:0] u;
    t10 = 7'(tens_of(c)) * 7'd10;
    u = c - t10;
    return u[3:0];
  endfunction

endpackage

@@ src/ducs_front.sv @@
// front part: debounce, lockout timers and digit mux timing, classifies each tick
// depends on ducs_pkg
module ducs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [ducs_pkg::BTN_COUNT-1:0] levels,
  input  ducs_pkg::cfg_t                 cfg,
  output ducs_pkg::entry_t               entry
);

  logic [ducs_pkg::BTN_COUNT-1:0] prev_levels, prev_levels_next;
  logic [ducs_pkg::BTN_COUNT-1:0] pressed, pressed_next;
  logic [7:0] timers [ducs_pkg::BTN_COUNT];
  logic [7:0] timers_next [ducs_pkg::BTN_COUNT];
  logic [7:0] mux_count, mux_count_next;
  logic right_active, right_active_next;
  logic [ducs_pkg::BTN_COUNT-1:0] act;

  always_comb begin
    logic [7:0] lock_len;
    logic [7:0] period;
    logic [8:0] step;
    logic [7:0] t;
    logic f;
    lock_len = (cfg.debounce_ticks == 8'd0) ? 8'd1 : cfg.debounce_ticks;
    period = (cfg.mux_period_ticks == 8'd0) ? 8'd1 : cfg.mux_period_ticks;
    step = {1'b0, mux_count} + 9'd1;
    if (step >= {1'b0, period}) begin
      mux_count_next = 8'd0;
      right_active_next = ~right_active;
    end else begin
      mux_count_next = step[7:0];
      right_active_next = right_active;
    end
    for (int i = 0; i < ducs_pkg::BTN_COUNT; i++) begin
      t = timers[i];
      f = pressed[i];
      if (t != 8'd0) begin
        t = t - 8'd1;
        if (t == 8'd0) f = ~f;
      end
      act[i] = 1'b0;
      if (prev_levels[i] && !levels[i]) begin
        if (t == 8'd0 && !f) begin
          t = lock_len;
          act[i] = 1'b1;
        end
      end else if (!prev_levels[i] && levels[i]) begin
        if (t == 8'd0 && f) t = lock_len;
      end
      timers_next[i] = t;
      pressed_next[i] = f;
    end
    prev_levels_next = levels;
  end

  always_comb begin
    entry.right_active = right_active_next;
    entry.act = act;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '1;
      pressed <= '0;
      for (int i = 0; i < ducs_pkg::BTN_COUNT; i++) timers[i] <= 8'd0;
      mux_count <= 8'd0;
      right_active <= 1'b0;
    end else if (accept) begin
      prev_levels <= prev_levels_next;
      pressed <= pressed_next;
      for (int i = 0; i < ducs_pkg::BTN_COUNT; i++) timers[i] <= timers_next[i];
      mux_count <= mux_count_next;
      right_active <= right_active_next;
    end
  end

endmodule

@@ src/ducs_queue.sv @@
// short queue of classified ticks between front and back parts
// depends on ducs_pkg
module ducs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ducs_pkg::entry_t     push_data,
  input  logic                 pop,
  output ducs_pkg::entry_t     pop_data,
  output ducs_pkg::q_status_t  status
);

  ducs_pkg::entry_t mem [ducs_pkg::QUEUE_DEPTH];
  logic [ducs_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ducs_pkg::QCNT_W-1:0] count;

  localparam logic [ducs_pkg::QPTR_W-1:0] LAST = ducs_pkg::QPTR_W'(ducs_pkg::QUEUE_DEPTH - 1);
  localparam logic [ducs_pkg::QCNT_W-1:0] FULL_COUNT =
    ducs_pkg::QCNT_W'(ducs_pkg::QUEUE_DEPTH);

  assign status.full = (count == FULL_COUNT);
  assign status.empty = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

@@ src/ducs_back.sv @@
// back part: applies button actions to the counter and drives the result register
// depends on ducs_pkg
module ducs_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              avail,
  input  ducs_pkg::entry_t  entry,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              right_digit_on,
  output logic [6:0]        segments,
  output logic [6:0]        count_value
);

  logic [6:0] counter, counter_next;
  logic [6:0] seg_next;

  assign pop = avail && (!result_valid || !result_stall);

  always_comb begin
    logic [6:0] c;
    c = counter;
    if (entry.act[ducs_pkg::BTN_RIGHT]) c = (c >= ducs_pkg::COUNT_TOP) ? 7'd0 : c + 7'd1;
    if (entry.act[ducs_pkg::BTN_LEFT] && c != 7'd0) c = c - 7'd1;
    if (entry.act[ducs_pkg::BTN_MIDDLE]) begin
      c = (c <= ducs_pkg::COUNT_TOP) ? ducs_pkg::COUNT_TOP - c : 7'd0;
    end
    counter_next = c;
    seg_next = entry.right_active ? ducs_pkg::digit_pattern(ducs_pkg::units_of(c))
                                  : ducs_pkg::digit_pattern(ducs_pkg::tens_of(c));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= 7'd0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        counter <= counter_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      right_digit_on <= entry.right_active;
      segments <= seg_next;
      count_value <= counter_next;
    end
  end

endmodule

@@ src/debounced_updown_counter_7seg_core.sv @@
// Debounced up/down counter with a two-digit multiplexed seven-segment display.
// Tick channel: tick_valid/tick_stall with the three raw active-low button
// levels; one request per time-base tick. Result channel: result_valid /
// result_stall with right_digit_on, segments and count_value, one result per
// request, in request order.
// A request is classified by the front part in the cycle it is taken and goes
// through a two-entry queue to the back part, which updates the counter and
// loads the result register. An accepted request is written into a queue entry,
// then into the result register as result_valid rises. Throughput is one request
// per clock while tick_stall is low, set by the back part's counter update.
// When the receiver stalls, the result register holds and the queue fills;
// tick_stall rises once the queue is full and falls once a result leaves.
// Reset (rst, synchronous) releases all buttons, clears lockouts, the mux count
// and the counter, empties the queue and loads debounce 10 and mux period 4.
// Configuration is through the APB-style port: register 0 at address 0 is the
// lockout length, register 1 at address 4 the mux period; write only when idle.
// depends on ducs_pkg, ducs_front, ducs_queue, ducs_back, assert_macros.svh
`include "assert_macros.svh"
module debounced_updown_counter_7seg_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick_valid,
  output logic                         tick_stall,
  input  logic                         right_button_level,
  input  logic                         left_button_level,
  input  logic                         middle_button_level,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         right_digit_on,
  output logic [6:0]                   segments,
  output logic [6:0]                   count_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ducs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  ducs_pkg::cfg_t cfg;
  ducs_pkg::entry_t front_entry, back_entry;
  ducs_pkg::q_status_t q_status;
  logic [ducs_pkg::BTN_COUNT-1:0] levels;
  logic tick_accept;
  logic pop;
  logic cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == ducs_pkg::REG_MUX_PERIOD) ? {24'd0, cfg.mux_period_ticks}
                                                         : {24'd0, cfg.debounce_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= ducs_pkg::DEBOUNCE_RESET;
      cfg.mux_period_ticks <= ducs_pkg::MUX_PERIOD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == ducs_pkg::REG_DEBOUNCE) cfg.debounce_ticks <= pwdata[7:0];
      else cfg.mux_period_ticks <= pwdata[7:0];
    end
  end

  assign levels[ducs_pkg::BTN_RIGHT] = right_button_level;
  assign levels[ducs_pkg::BTN_LEFT] = left_button_level;
  assign levels[ducs_pkg::BTN_MIDDLE] = middle_button_level;

  assign tick_stall = q_status.full;
  assign tick_accept = tick_valid && !tick_stall;

  ducs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (tick_accept),
    .levels (levels),
    .cfg    (cfg),
    .entry  (front_entry)
  );

  ducs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tick_accept),
    .push_data (front_entry),
    .pop       (pop),
    .pop_data  (back_entry),
    .status    (q_status)
  );

  ducs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .avail          (!q_status.empty),
    .entry          (back_entry),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .right_digit_on (right_digit_on),
    .segments       (segments),
    .count_value    (count_value)
  );

  `ASSERT_IMPLIES(a_count_range, clk, rst, result_valid, count_value <= ducs_pkg::COUNT_TOP, "count out of range")
  `ASSERT_NEVER(a_queue_status, clk, rst, q_status.full && q_status.empty, "queue full and empty")
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, pop, !q_status.empty, "pop from empty queue")
  `ASSERT_IMPLIES(a_result_hold, clk, rst, result_valid && result_stall, ##1 result_valid && $stable(count_value), "stalled result changed")

endmodule
